@@ src/cbf_pkg.sv @@
// Shared operation codes, field widths and control structs for the byte ring buffer.
package cbf_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int KIND_W  = 3;

    // Operation codes carried on the kind field
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COPY    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    // Capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // item taken this cycle
        logic step;     // fetch one byte of a read or copy walk
    } cbf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic xfer_zero;  // read or copy would move no bytes
        logic walk_last;  // current walk step is the final one
    } cbf_stat_t;

endpackage

@@ src/cbf_ctrl.sv @@
// Controller: accepts items, sequences read and copy walks, drives result strobes.
module cbf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cbf_pkg::KIND_W-1:0]    kind,
    input  logic                          burst_end,
    input  cbf_pkg::cbf_stat_t            stat,
    output cbf_pkg::cbf_cmd_t             cmd,
    output logic                          busy,
    output logic                          strobe,
    output logic                          byte_valid,
    output logic                          last
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg;
    logic   strobe_reg;
    logic   byte_valid_reg;
    logic   last_reg;
    logic   is_xfer;

    // Decode commands
    assign is_xfer    = (kind == cbf_pkg::KIND_READ) || (kind == cbf_pkg::KIND_COPY);
    assign cmd.accept = start && (state_reg == ST_IDLE);
    assign cmd.step   = (state_reg == ST_WALK);
    assign busy       = (state_reg == ST_WALK);

    assign strobe     = strobe_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;

    // Hold state and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            strobe_reg     <= 1'b0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    strobe_reg     <= 1'b0;
                    byte_valid_reg <= 1'b0;
                    last_reg       <= 1'b0;
                    if (cmd.accept)
                    begin
                        case (kind) inside
                            cbf_pkg::KIND_WRITE:
                            begin
                                strobe_reg <= burst_end;
                                last_reg   <= 1'b1;
                            end
                            cbf_pkg::KIND_READ, cbf_pkg::KIND_COPY:
                            begin
                                if (stat.xfer_zero)
                                begin
                                    strobe_reg <= 1'b1;
                                    last_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_WALK;
                                end
                            end
                            default:
                            begin
                                strobe_reg <= 1'b1;
                                last_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    strobe_reg     <= 1'b1;
                    byte_valid_reg <= 1'b1;
                    last_reg       <= stat.walk_last;
                    if (stat.walk_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // A data beat always comes with the strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg |-> strobe_reg)
        else $error("data beat without strobe");

    // Every walk step yields a data beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |=> (strobe_reg && byte_valid_reg))
        else $error("walk step produced no data beat");

    // A data beat that is not last means the walk is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && !last_reg) |-> (state_reg == ST_WALK))
        else $error("walk ended before its last beat");

    // A read or copy that moves bytes starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_xfer && !stat.xfer_zero) |=> (state_reg == ST_WALK))
        else $error("nonempty transfer did not start a walk");

endmodule

@@ src/cbf_dp.sv @@
// Datapath: ring storage, pointers, occupancy arithmetic and result payload registers.
module cbf_dp #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbf_pkg::cbf_cmd_t             cmd,
    input  logic [cbf_pkg::KIND_W-1:0]    kind,
    input  logic [cbf_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          burst_end,
    input  logic [cbf_pkg::COUNT_W-1:0]   count,
    input  logic                          cfg_write,
    input  logic [cbf_pkg::COUNT_W-1:0]   cfg_data,
    output cbf_pkg::cbf_stat_t            stat,
    output logic [cbf_pkg::BYTE_W-1:0]    out_byte,
    output logic [cbf_pkg::COUNT_W-1:0]   moved_count,
    output logic [cbf_pkg::COUNT_W-1:0]   bytes_used,
    output logic                          full_res,
    output logic                          empty_res
);

    localparam int CW      = cbf_pkg::COUNT_W;
    localparam int PW      = $clog2(DEPTH);
    localparam int AW      = ((PW > CW) ? PW : CW) + 1;
    localparam int RW      = $clog2(MAX_BURST + 1);
    localparam int CAP_MAX = (DEPTH < 511) ? DEPTH : 511;

    logic [cbf_pkg::BYTE_W-1:0] mem [DEPTH];

    logic [PW-1:0]  wp_reg, rp_reg, walk_reg;
    logic           holds_reg;
    logic [CW-1:0]  burst_reg;
    logic [CW-1:0]  cap_reg;
    logic [RW-1:0]  rem_reg;

    logic [cbf_pkg::BYTE_W-1:0] rd_reg;
    logic [CW-1:0]  moved_reg, used_reg;
    logic           full_reg, empty_reg;

    logic [CW-1:0]  eff_cap;
    logic [CW-1:0]  used_c, used_next;
    logic           room;
    logic [CW-1:0]  burst_inc;
    logic [CW-1:0]  lim, xfer_n, disc_n, skip_n, moved_next;
    logic [AW-1:0]  skip_sum;
    logic [PW-1:0]  rp_skip;
    logic [PW-1:0]  wp_next, rp_next;
    logic           holds_next;
    logic [CW-1:0]  burst_next;

    // Occupancy from pointers and the data flag
    function automatic logic [CW-1:0] occ(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                          input logic h, input logic [CW-1:0] c);
        logic [AW-1:0] we;
        logic [AW-1:0] re;
        we = AW'(w);
        re = AW'(r);
        if (we > re)
            return CW'(we - re);
        else if (re > we)
            return CW'(AW'(c) - (re - we));
        else
            return h ? c : '0;
    endfunction

    // Step a pointer with wrap at the capacity
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] c);
        logic [AW-1:0] nx;
        nx = AW'(p) + AW'(1);
        return (nx >= AW'(c)) ? '0 : PW'(nx);
    endfunction

    // Clamp the capacity register to the usable range
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CW'(1);
        else if (cap_reg > CW'(CAP_MAX))
            eff_cap = CW'(CAP_MAX);
        else
            eff_cap = cap_reg;
    end

    // Work out the effect of the offered item
    always_comb
    begin
        used_c    = occ(wp_reg, rp_reg, holds_reg, eff_cap);
        room      = (used_c < eff_cap);
        burst_inc = (burst_reg != '1) ? burst_reg + CW'(1) : burst_reg;
        lim       = (count > CW'(MAX_BURST)) ? CW'(MAX_BURST) : count;
        xfer_n    = (lim > used_c) ? used_c : lim;
        disc_n    = ((count != '0) && (count < used_c)) ? count : used_c;
        skip_n    = (kind == cbf_pkg::KIND_DISCARD) ? disc_n : xfer_n;
        skip_sum  = AW'(rp_reg) + AW'(skip_n);
        rp_skip   = (skip_sum >= AW'(eff_cap)) ? PW'(skip_sum - AW'(eff_cap)) : PW'(skip_sum);

        wp_next    = wp_reg;
        rp_next    = rp_reg;
        holds_next = holds_reg;
        burst_next = burst_reg;
        moved_next = '0;

        case (kind)
            cbf_pkg::KIND_WRITE:
            begin
                if (room)
                begin
                    wp_next    = adv(wp_reg, eff_cap);
                    holds_next = 1'b1;
                    burst_next = burst_inc;
                end
                moved_next = room ? burst_inc : burst_reg;
                if (burst_end)
                    burst_next = '0;
            end
            cbf_pkg::KIND_READ:
            begin
                moved_next = xfer_n;
                if (xfer_n != '0)
                begin
                    rp_next    = rp_skip;
                    holds_next = (rp_skip != wp_reg);
                end
            end
            cbf_pkg::KIND_COPY:
            begin
                moved_next = xfer_n;
            end
            cbf_pkg::KIND_DISCARD:
            begin
                moved_next = disc_n;
                rp_next    = rp_skip;
                holds_next = (rp_skip != wp_reg);
            end
            cbf_pkg::KIND_CLEAR:
            begin
                wp_next    = '0;
                rp_next    = '0;
                holds_next = 1'b0;
            end
            default:
            begin
                moved_next = '0;
            end
        endcase

        used_next = occ(wp_next, rp_next, holds_next, eff_cap);
    end

    // Report to the controller
    assign stat.xfer_zero = (xfer_n == '0);
    assign stat.walk_last = (rem_reg == RW'(1));

    // Update ring pointers, flag, burst tally and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            holds_reg <= 1'b0;
            burst_reg <= '0;
            cap_reg   <= cbf_pkg::CAP_RESET;
            walk_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg   <= cfg_data;
                wp_reg    <= '0;
                rp_reg    <= '0;
                holds_reg <= 1'b0;
                burst_reg <= '0;
            end
            else if (cmd.accept)
            begin
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                holds_reg <= holds_next;
                burst_reg <= burst_next;
            end

            // Load or advance the walk cursor
            if (cmd.accept)
            begin
                walk_reg <= rp_reg;
                rem_reg  <= RW'(xfer_n);
            end
            else if (cmd.step)
            begin
                walk_reg <= adv(walk_reg, eff_cap);
                rem_reg  <= rem_reg - RW'(1);
            end
        end
    end

    // Latch the status fields of the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            moved_reg <= moved_next;
            used_reg  <= used_next;
            full_reg  <= holds_next && (wp_next == rp_next);
            empty_reg <= !holds_next;
        end
    end

    // Store written bytes and fetch walk bytes
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (kind == cbf_pkg::KIND_WRITE) && room)
            mem[wp_reg] <= data_byte;
        if (cmd.step)
            rd_reg <= mem[walk_reg];
        else if (cmd.accept)
            rd_reg <= '0;
    end

    assign out_byte    = rd_reg;
    assign moved_count = moved_reg;
    assign bytes_used  = used_reg;
    assign full_res    = full_reg;
    assign empty_res   = empty_reg;

endmodule

@@ src/circular_byte_fifo_peek_discard.sv @@
// A burst-ending write, discard, clear or empty transfer reports in the next cycle.
// Writes are taken every cycle while not busy; a read or copy holds busy while it walks,
// one ring memory read per cycle, and each beat follows in the cycle after its read.
// Results are single-cycle beats on strobe; the receiver cannot stall them.
// Reset: pointers, data flag and burst tally clear, capacity returns to 256; ring
// contents are not cleared and need no clearing pass.
module circular_byte_fifo_peek_discard #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cbf_pkg::KIND_W-1:0]    kind,
    input  logic [cbf_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          burst_end,
    input  logic [cbf_pkg::COUNT_W-1:0]   count,
    input  logic                          cfg_write,
    input  logic [cbf_pkg::COUNT_W-1:0]   cfg_data,
    output logic                          strobe,
    output logic [cbf_pkg::BYTE_W-1:0]    out_byte,
    output logic                          byte_valid,
    output logic                          last,
    output logic [cbf_pkg::COUNT_W-1:0]   moved_count,
    output logic [cbf_pkg::COUNT_W-1:0]   bytes_used,
    output logic                          full_res,
    output logic                          empty_res
);

    cbf_pkg::cbf_cmd_t  cmd;
    cbf_pkg::cbf_stat_t stat;

    // Sequence items and result beats
    cbf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .burst_end  (burst_end),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .strobe     (strobe),
        .byte_valid (byte_valid),
        .last       (last)
    );

    // Hold the ring and compute occupancy
    cbf_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .data_byte   (data_byte),
        .burst_end   (burst_end),
        .count       (count),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .stat        (stat),
        .out_byte    (out_byte),
        .moved_count (moved_count),
        .bytes_used  (bytes_used),
        .full_res    (full_res),
        .empty_res   (empty_res)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the byte ring buffer with peek, discard and clear.
module tb;

    localparam int KIND_W        = cbf_pkg::KIND_W;
    localparam int BYTE_W        = cbf_pkg::BYTE_W;
    localparam int COUNT_W       = cbf_pkg::COUNT_W;
    localparam int RING_DEPTH    = 256;
    localparam int BURST_MAX     = 64;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int TALLY_MAX     = 511;
    localparam int PHASES        = 9;

    // One item offered to the block
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data;
        logic               bend;
        logic [COUNT_W-1:0] count;
    } fifo_op_t;

    // One result beat
    typedef struct {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic [COUNT_W-1:0] moved_count;
        logic [COUNT_W-1:0] bytes_used;
        logic               full_res;
        logic               empty_res;
    } ring_beat_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    logic [KIND_W-1:0]  kind      = cbf_pkg::KIND_WRITE;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic               burst_end = 1'b0;
    logic [COUNT_W-1:0] count     = '0;
    logic               cfg_write = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               strobe;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last;
    logic [COUNT_W-1:0] moved_count;
    logic [COUNT_W-1:0] bytes_used;
    logic               full_res;
    logic               empty_res;

    // Pending items and beats still owed by the block
    fifo_op_t   op_q [$];
    ring_beat_t due_beats [$];
    logic       op_taken    = 1'b0;
    int unsigned gap_pct    = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Shadow copy of the ring
    logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
    int unsigned        wr_ptr  = 0;
    int unsigned        rd_ptr  = 0;
    logic               holding = 1'b0;
    int unsigned        tally   = 0;
    logic [COUNT_W-1:0] cap_reg = cbf_pkg::CAP_RESET;

    // Random phase plan: capacity, item count, share of write bytes, sender gaps
    int unsigned phase_cap   [PHASES] = '{1, 256, 0, 2, 7, 511, 64, 300, 37};
    int unsigned phase_items [PHASES] = '{30, 110, 20, 30, 40, 40, 50, 20, 20};
    int unsigned phase_wpct  [PHASES] = '{60, 80, 60, 55, 55, 65, 70, 50, 60};
    // no gaps, sender gaps, receiver stalls (cannot apply here), both
    int unsigned gap_plan    [4]      = '{0, 45, 0, 14};

    circular_byte_fifo_peek_discard #(
        .DEPTH     (RING_DEPTH),
        .MAX_BURST (BURST_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .data_byte   (data_byte),
        .burst_end   (burst_end),
        .count       (count),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .moved_count (moved_count),
        .bytes_used  (bytes_used),
        .full_res    (full_res),
        .empty_res   (empty_res)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Capacity clamped to what the ring can hold
    function automatic int unsigned ring_cap();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > RING_DEPTH)
            return RING_DEPTH;
        return cap_reg;
    endfunction

    function automatic int unsigned ring_fill();
        if (wr_ptr > rd_ptr)
            return wr_ptr - rd_ptr;
        if (rd_ptr > wr_ptr)
            return ring_cap() - (rd_ptr - wr_ptr);
        return holding ? ring_cap() : 0;
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p);
        return (p + 1 >= ring_cap()) ? 0 : p + 1;
    endfunction

    // Queue one beat, status taken from the ring after the whole item
    function automatic void owe_beat(input logic [BYTE_W-1:0] b, input logic v,
                                     input logic l, input int unsigned moved);
        ring_beat_t e;
        e.out_byte    = b;
        e.byte_valid  = v;
        e.last        = l;
        e.moved_count = COUNT_W'(moved);
        e.bytes_used  = COUNT_W'(ring_fill());
        e.full_res    = (wr_ptr == rd_ptr) && holding;
        e.empty_res   = !holding;
        due_beats.push_back(e);
    endfunction

    // Advance the shadow ring by one item and queue the beats it owes
    function automatic void predict_ring_beats(input fifo_op_t op);
        int unsigned      n;
        int unsigned      i;
        int unsigned      p;
        logic [BYTE_W-1:0] walked [$];
        case (op.kind) inside
            cbf_pkg::KIND_WRITE:
            begin
                if (ring_fill() < ring_cap())
                begin
                    ring_mem[wr_ptr] = op.data;
                    wr_ptr = step_ptr(wr_ptr);
                    holding = 1'b1;
                    if (tally < TALLY_MAX)
                        tally++;
                end
                if (op.bend)
                begin
                    n = tally;
                    tally = 0;
                    owe_beat('0, 1'b0, 1'b1, n);
                end
            end
            cbf_pkg::KIND_READ, cbf_pkg::KIND_COPY:
            begin
                n = op.count;
                if (n > BURST_MAX)
                    n = BURST_MAX;
                if (n > ring_fill())
                    n = ring_fill();
                if (n == 0)
                    owe_beat('0, 1'b0, 1'b1, 0);
                else
                begin
                    p = rd_ptr;
                    for (i = 0; i < n; i++)
                    begin
                        walked.push_back(ring_mem[p]);
                        p = step_ptr(p);
                    end
                    // only a read consumes what it walked
                    if (op.kind == cbf_pkg::KIND_READ)
                    begin
                        rd_ptr = p;
                        if (rd_ptr == wr_ptr)
                            holding = 1'b0;
                    end
                    for (i = 0; i < n; i++)
                        owe_beat(walked[i], 1'b1, i + 1 == n, n);
                end
            end
            cbf_pkg::KIND_DISCARD:
            begin
                n = ring_fill();
                if (op.count != 0 && op.count < n)
                    n = op.count;
                for (i = 0; i < n; i++)
                    rd_ptr = step_ptr(rd_ptr);
                if (rd_ptr == wr_ptr)
                    holding = 1'b0;
                owe_beat('0, 1'b0, 1'b1, n);
            end
            cbf_pkg::KIND_CLEAR:
            begin
                // the burst tally survives a clear
                wr_ptr = 0;
                rd_ptr = 0;
                holding = 1'b0;
                owe_beat('0, 1'b0, 1'b1, 0);
            end
            default:
            begin
                owe_beat('0, 1'b0, 1'b1, 0);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: beat error: %s", $time, what);
    endtask

    // Sample accepted items, then check any beat on the result ports
    always @(posedge clk)
    begin
        fifo_op_t   seen_op;
        ring_beat_t want;
        cycle_count++;
        op_taken = rst_n && start && !busy;
        if (op_taken)
        begin
            seen_op.kind  = kind;
            seen_op.data  = data_byte;
            seen_op.bend  = burst_end;
            seen_op.count = count;
            predict_ring_beats(seen_op);
        end
        if (rst_n && strobe)
        begin
            if (due_beats.size() == 0)
                report_mismatch("beat with nothing outstanding");
            else
            begin
                want = due_beats.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %0h, want %0h", out_byte, want.out_byte));
                if (byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %0b, want %0b",
                                              byte_valid, want.byte_valid));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
                if (moved_count !== want.moved_count)
                    report_mismatch($sformatf("moved_count %0d, want %0d",
                                              moved_count, want.moved_count));
                if (bytes_used !== want.bytes_used)
                    report_mismatch($sformatf("bytes_used %0d, want %0d",
                                              bytes_used, want.bytes_used));
                if (full_res !== want.full_res)
                    report_mismatch($sformatf("full_res %0b, want %0b", full_res, want.full_res));
                if (empty_res !== want.empty_res)
                    report_mismatch($sformatf("empty_res %0b, want %0b",
                                              empty_res, want.empty_res));
            end
        end
    end

    // Present the next item once the current one is taken, with random gaps
    always @(negedge clk)
    begin
        fifo_op_t nxt;
        logic     drive_next;
        if (rst_n && (!start || op_taken))
        begin
            drive_next = 1'b0;
            if (op_q.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                nxt = op_q.pop_front();
                kind      <= nxt.kind;
                data_byte <= nxt.data;
                burst_end <= nxt.bend;
                count     <= nxt.count;
                drive_next = 1'b1;
            end
            start <= drive_next;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("circular_byte_fifo_peek_discard: mismatch");
            $finish;
        end
    end

    function automatic void queue_op(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
                                     input logic e, input logic [COUNT_W-1:0] c);
        fifo_op_t op;
        op.kind  = k;
        op.data  = d;
        op.bend  = e;
        op.count = c;
        op_q.push_back(op);
    endfunction

    // Mostly small counts, some past the burst limit, some across the full field
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll <= 5)
            return COUNT_W'($urandom_range(1, 8));
        if (roll <= 7)
            return COUNT_W'($urandom_range(9, 70));
        return COUNT_W'($urandom_range(0, 511));
    endfunction

    // Write bursts with random content, mixed with the other operations
    function automatic void queue_random_ops(input int unsigned n, input int unsigned write_pct);
        int unsigned made;
        int unsigned len;
        int unsigned i;
        int unsigned roll;
        logic        open_burst;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < write_pct)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
                // now and then leave a burst without its end marker
                open_burst = ($urandom_range(0, 15) == 0);
                for (i = 0; i < len; i++)
                    queue_op(cbf_pkg::KIND_WRITE, BYTE_W'($urandom),
                             (i + 1 == len) && !open_burst, COUNT_W'($urandom));
                made += len;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    queue_op(cbf_pkg::KIND_READ, BYTE_W'($urandom), 1'($urandom),
                             pick_count());
                else if (roll < 65)
                    queue_op(cbf_pkg::KIND_COPY, BYTE_W'($urandom), 1'($urandom),
                             pick_count());
                else if (roll < 82)
                    queue_op(cbf_pkg::KIND_DISCARD, BYTE_W'($urandom), 1'($urandom),
                             pick_count());
                else if (roll < 92)
                    queue_op(cbf_pkg::KIND_CLEAR, BYTE_W'($urandom), 1'($urandom),
                             COUNT_W'($urandom));
                else
                    queue_op(cbf_pkg::KIND_CLEAR + KIND_W'($urandom_range(1, 3)),
                             BYTE_W'($urandom), 1'($urandom), COUNT_W'($urandom));
                made++;
            end
        end
    endfunction

    // Hold until every item is taken and every beat has come, then settle
    task automatic wait_drained();
        while (op_q.size() != 0 || start || due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity while the block is idle; the ring empties
    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cap_reg = value;
        wr_ptr  = 0;
        rd_ptr  = 0;
        holding = 1'b0;
        tally   = 0;
    endtask

    initial
    begin
        int unsigned k;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty ring, short bursts, walks, clear inside a burst, unknown kinds
        gap_pct = 0;
        queue_op(cbf_pkg::KIND_READ, 8'h00, 1'b0, 9'd5);
        queue_op(cbf_pkg::KIND_COPY, 8'hFF, 1'b1, 9'h1FF);
        queue_op(cbf_pkg::KIND_DISCARD, 8'h00, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_CLEAR, 8'hFF, 1'b1, 9'h1FF);
        queue_op(cbf_pkg::KIND_WRITE, 8'h00, 1'b0, 9'h1FF);
        queue_op(cbf_pkg::KIND_WRITE, 8'hFF, 1'b0, 9'h000);
        queue_op(cbf_pkg::KIND_WRITE, 8'hA5, 1'b1, 9'h155);
        queue_op(cbf_pkg::KIND_COPY, 8'h00, 1'b0, 9'd2);
        queue_op(cbf_pkg::KIND_COPY, 8'h00, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_READ, 8'h00, 1'b0, 9'd511);
        queue_op(cbf_pkg::KIND_WRITE, 8'h5A, 1'b1, 9'h0AA);
        queue_op(cbf_pkg::KIND_WRITE, 8'h3C, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_WRITE, 8'hC3, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_CLEAR, 8'h00, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_WRITE, 8'h81, 1'b1, 9'd0);
        queue_op(cbf_pkg::KIND_WRITE, 8'h7E, 1'b1, 9'd0);
        queue_op(cbf_pkg::KIND_DISCARD, 8'h00, 1'b0, 9'd1);
        queue_op(cbf_pkg::KIND_DISCARD, 8'h00, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_READ, 8'h00, 1'b0, 9'd64);
        queue_op(cbf_pkg::KIND_CLEAR + KIND_W'(1), 8'hFF, 1'b1, 9'h1FF);
        queue_op(cbf_pkg::KIND_CLEAR + KIND_W'(2), 8'h00, 1'b0, 9'd0);
        queue_op(cbf_pkg::KIND_CLEAR + KIND_W'(3), 8'h55, 1'b1, 9'h100);
        wait_drained();

        // Random phases, one capacity each
        for (k = 0; k < PHASES; k++)
        begin
            write_capacity(COUNT_W'(phase_cap[k]));
            gap_pct = gap_plan[k % 4];
            queue_random_ops(phase_items[k], phase_wpct[k]);
            wait_drained();
        end

        if (mismatches == 0)
            $display("circular_byte_fifo_peek_discard: match");
        else
            $display("circular_byte_fifo_peek_discard: mismatch");
        $finish;
    end

endmodule
